FILE: sv/rcsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcsp_pkg
// Shared types and codes of the refcounted cell slot pool.
// ----------------------------------------------------------------------------
package rcsp_pkg;

  typedef struct packed {
    logic [2:0]          operation;
    logic signed [31:0]  world_x;
    logic signed [31:0]  world_y;
    logic [3:0]          slot_index;
  } in_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [1:0]          status;
    logic [3:0]          slot;
    logic signed [31:0]  cell_x;
    logic signed [31:0]  cell_y;
    logic signed [31:0]  origin_x;
    logic signed [31:0]  origin_y;
    logic [15:0]         uv_u;
    logic [15:0]         uv_v;
    logic                occupied;
    logic [4:0]          active_count;
    logic                last;
  } out_t;

  // One pool slot as held by a cell of the ring
  typedef struct packed {
    logic                valid;
    logic signed [31:0]  cell_x;
    logic signed [31:0]  cell_y;
    logic signed [31:0]  origin_x;
    logic signed [31:0]  origin_y;
    logic [15:0]         refs;
    logic                released;
    logic [31:0]         rel_time;
  } slot_t;

  // Dividend of one divider lane: sign and magnitude
  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } div_num_t;

  localparam logic [2:0] OP_REGISTER   = 3'd0;
  localparam logic [2:0] OP_UNREGISTER = 3'd1;
  localparam logic [2:0] OP_LOOKUP     = 3'd2;
  localparam logic [2:0] OP_TICK       = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;

  localparam logic [1:0] KIND_ANSWER    = 2'd0;
  localparam logic [1:0] KIND_ASSIGNED  = 2'd1;
  localparam logic [1:0] KIND_RECLAIMED = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;
  localparam logic [1:0] STAT_BAD_SLOT  = 2'd3;

  localparam logic [1:0] CFG_CELL_SIZE    = 2'd0;
  localparam logic [1:0] CFG_DECAY_TICKS  = 2'd1;
  localparam logic [1:0] CFG_ACTIVE_SLOTS = 2'd2;

  localparam logic signed [31:0] FREE_ORIGIN = -32'sd9999999;
  localparam logic [15:0]        MIN_CELL    = 16'd100;
  localparam logic [15:0]        REFS_MAX    = 16'hFFFF;
  localparam logic [15:0]        UV_MAX      = 16'hFFFF;
  localparam logic signed [31:0] INT32_MAX   = 32'sh7FFFFFFF;
  localparam logic signed [31:0] INT32_MIN   = 32'sh80000000;

endpackage
`default_nettype wire

FILE: sv/rcsp_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcsp_cell
// One slot of the pool ring; takes its neighbor's slot on every shift.
// ----------------------------------------------------------------------------
module rcsp_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  rcsp_pkg::slot_t     d,
  output rcsp_pkg::slot_t     q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid    <= 1'b0;
      q.cell_x   <= '0;
      q.cell_y   <= '0;
      q.origin_x <= rcsp_pkg::FREE_ORIGIN;
      q.origin_y <= rcsp_pkg::FREE_ORIGIN;
      q.refs     <= '0;
      q.released <= 1'b0;
      q.rel_time <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rcsp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcsp_div
// Two-lane restoring divider, one quotient bit per cycle.
// Gives floor(num / divisor) for a signed dividend.
// ----------------------------------------------------------------------------
module rcsp_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  rcsp_pkg::div_num_t      num_x,
  input  rcsp_pkg::div_num_t      num_y,
  input  logic [15:0]             divisor,
  output logic                    busy,
  output logic signed [31:0]      quo_x,
  output logic signed [31:0]      quo_y
);

  logic [4:0]  step;
  logic [15:0] dv;
  logic [31:0] qx, qy;
  logic [15:0] rx, ry;
  logic        nx, ny;
  logic [47:0] sx, sy;

  function automatic logic [47:0] div_step(input logic [31:0] q, input logic [15:0] r,
                                           input logic [15:0] d);
    logic [16:0] t;
    logic        b;
    t = {r, q[31]};
    b = (t >= {1'b0, d});
    if (b) t = t - {1'b0, d};
    return {q[30:0], b, t[15:0]};
  endfunction

  assign sx = div_step(qx, rx, dv);
  assign sy = div_step(qy, ry, dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 5'd1;
      if (step == 5'd31) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv <= divisor;
      qx <= num_x.mag;
      qy <= num_y.mag;
      rx <= '0;
      ry <= '0;
      nx <= num_x.neg;
      ny <= num_y.neg;
    end else if (busy) begin
      qx <= sx[47:16];
      rx <= sx[15:0];
      qy <= sy[47:16];
      ry <= sy[15:0];
    end
  end

  // round toward minus infinity for negative dividends
  assign quo_x = nx ? $signed(32'd0 - (qx + 32'(rx != 16'd0))) : $signed(qx);
  assign quo_y = ny ? $signed(32'd0 - (qy + 32'(ry != 16'd0))) : $signed(qy);

endmodule
`default_nettype wire

FILE: sv/refcounted_cell_slot_pool.sv
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_cell_slot_pool
// Reference-counted pool of slots mapping world grid cells to slots.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one operation per beat:
// register, unregister, lookup, tick or slot query. Output channel
// out_valid/out_stall/out_data returns the events of the operation (cell
// assigned, cell reclaimed) followed by one answer beat with last set.
// Configuration (cell size, decay ticks, active slots) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is
// idle, as the block itself does not enforce it. The slots sit in a ring
// of POOL_SIZE cells that rotates one slot per cycle during a ring pass
// (save where a tick pass pauses) past a single evaluation point. An item
// goes through the cell divider, a multiply step, a ring pass to search, a
// decide step and, where state changes, a second ring pass, then emits its
// result beats one at a time. Lookup adds a UV division.
// One item is in flight at a time; in_stall is high from acceptance until
// the answer beat is loaded. The output register holds a beat while
// out_stall is high; during a tick pass the ring pauses while a beat waits
// there stalled. Reset (synchronous) frees every slot, clears time and
// loads config defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module refcounted_cell_slot_pool #(
  parameter int POOL_SIZE = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rcsp_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rcsp_pkg::out_t      out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [4:0]    POOL_N   = 5'(POOL_SIZE);
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SIZE - 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DIV    = 8'b0000_0010,
    ST_MUL    = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_DECIDE = 8'b0001_0000,
    ST_APPLY  = 8'b0010_0000,
    ST_UV     = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    AP_NONE, AP_INC, AP_ASSIGN, AP_DEC, AP_TICK
  } apply_t;

  state_t state;
  apply_t apk;

  logic [15:0] cell_size;
  logic [31:0] decay_ticks;
  logic [4:0]  active_slots;
  logic [31:0] now;

  logic [2:0]         op;
  logic signed [31:0] wx, wy;
  logic [3:0]         qi;
  logic [4:0]         n;
  logic [15:0]        cs;
  logic signed [31:0] cx, cy;
  logic signed [48:0] prod_x, prod_y;
  logic [IW-1:0]      idx;

  logic               found, freef, best;
  logic [IW-1:0]      fidx, fridx, bidx, tgt;
  rcsp_pkg::slot_t    fslot, qslot;
  logic [31:0]        bage;
  logic signed [31:0] bcx, bcy;
  logic [4:0]         act, act_t, act_fin;
  logic               emit_recl, emit_asgn;
  logic               uz, us, vz, vs;
  rcsp_pkg::out_t     ans;

  rcsp_pkg::slot_t    cell_q [POOL_SIZE];
  rcsp_pkg::slot_t    h, hm;
  logic               shift, idx_on, evictable, expired;
  logic [31:0]        age;
  logic signed [31:0] org_x, org_y;
  logic signed [32:0] dx, dy;
  logic               ob_free, load, acc;
  rcsp_pkg::out_t     ld;

  logic               div_start, div_busy;
  rcsp_pkg::div_num_t num_x, num_y;
  logic signed [31:0] quo_x, quo_y;
  logic [15:0]        cs_in;
  logic [4:0]         n_in;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'(rcsp_pkg::INT32_MAX)) return rcsp_pkg::INT32_MAX;
    if (v < 49'(rcsp_pkg::INT32_MIN)) return rcsp_pkg::INT32_MIN;
    return v[31:0];
  endfunction

  // ring of slot cells; cell 0 is the evaluation point
  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_ring
    rcsp_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     ((i == POOL_SIZE - 1) ? hm : cell_q[(i + 1) % POOL_SIZE]),
      .q     (cell_q[i])
    );
  end

  assign in_stall = (state != ST_IDLE);
  assign acc      = in_valid && (state == ST_IDLE);
  assign ob_free  = !out_valid || !out_stall;

  assign cs_in = (cell_size < rcsp_pkg::MIN_CELL) ? rcsp_pkg::MIN_CELL : cell_size;
  assign n_in  = (active_slots == 5'd0) ? 5'd1 :
                 (active_slots > POOL_N) ? POOL_N : active_slots;

  assign org_x = sat32(prod_x);
  assign org_y = sat32(prod_y);
  assign dx    = {wx[31], wx} - {fslot.origin_x[31], fslot.origin_x};
  assign dy    = {wy[31], wy} - {fslot.origin_y[31], fslot.origin_y};

  // divider feed: world position on accept, UV offset on lookup
  always_comb begin
    div_start = acc || (state == ST_DECIDE && op == rcsp_pkg::OP_LOOKUP && found);
    if (state == ST_IDLE) begin
      num_x.neg = in_data.world_x[31];
      num_x.mag = in_data.world_x[31] ? 32'd0 - in_data.world_x : in_data.world_x;
      num_y.neg = in_data.world_y[31];
      num_y.mag = in_data.world_y[31] ? 32'd0 - in_data.world_y : in_data.world_y;
    end else begin
      num_x.neg = 1'b0;
      num_x.mag = {dx[15:0], 16'h0000};
      num_y.neg = 1'b0;
      num_y.mag = {dy[15:0], 16'h0000};
    end
  end

  rcsp_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num_x   (num_x),
    .num_y   (num_y),
    .divisor ((state == ST_IDLE) ? cs_in : cs),
    .busy    (div_busy),
    .quo_x   (quo_x),
    .quo_y   (quo_y)
  );

  // evaluation point: flags, write-back, tick reclaim beats and emitted beats
  always_comb begin
    h         = cell_q[0];
    hm        = h;
    idx_on    = (5'(idx) < n);
    age       = now - h.rel_time;
    evictable = h.valid && (h.refs == 16'd0) && h.released;
    expired   = evictable && (age >= decay_ticks);
    load      = 1'b0;
    ld        = '0;
    ld.active_count = act_fin;
    shift     = (state == ST_SCAN) ||
                (state == ST_APPLY && (apk != AP_TICK || ob_free));

    if (state == ST_APPLY && idx_on) begin
      case (apk)
        AP_TICK: begin
          if (expired && ob_free) begin
            hm.valid    = 1'b0;
            hm.released = 1'b0;
            hm.origin_x = rcsp_pkg::FREE_ORIGIN;
            hm.origin_y = rcsp_pkg::FREE_ORIGIN;
            load        = 1'b1;
            ld.kind     = rcsp_pkg::KIND_RECLAIMED;
            ld.slot     = 4'(idx);
            ld.cell_x   = h.cell_x;
            ld.cell_y   = h.cell_y;
            ld.origin_x = rcsp_pkg::FREE_ORIGIN;
            ld.origin_y = rcsp_pkg::FREE_ORIGIN;
          end
        end
        AP_INC: begin
          if (idx == tgt) begin
            if (h.refs != rcsp_pkg::REFS_MAX) hm.refs = h.refs + 16'd1;
            hm.released = 1'b0;
          end
        end
        AP_ASSIGN: begin
          if (idx == tgt) begin
            hm.valid    = 1'b1;
            hm.cell_x   = cx;
            hm.cell_y   = cy;
            hm.origin_x = org_x;
            hm.origin_y = org_y;
            hm.refs     = 16'd1;
            hm.released = 1'b0;
          end
        end
        AP_DEC: begin
          if (idx == tgt) begin
            hm.refs = (h.refs != 16'd0) ? h.refs - 16'd1 : 16'd0;
            if (hm.refs == 16'd0) begin
              hm.released = 1'b1;
              hm.rel_time = now;
            end
          end
        end
        default: ;
      endcase
    end

    if (state == ST_EMIT && ob_free) begin
      load = 1'b1;
      if (emit_recl) begin
        ld.kind     = rcsp_pkg::KIND_RECLAIMED;
        ld.slot     = 4'(tgt);
        ld.cell_x   = bcx;
        ld.cell_y   = bcy;
        ld.origin_x = rcsp_pkg::FREE_ORIGIN;
        ld.origin_y = rcsp_pkg::FREE_ORIGIN;
      end else if (emit_asgn) begin
        ld.kind     = rcsp_pkg::KIND_ASSIGNED;
        ld.slot     = 4'(tgt);
        ld.cell_x   = cx;
        ld.cell_y   = cy;
        ld.origin_x = org_x;
        ld.origin_y = org_y;
        ld.occupied = 1'b1;
      end else begin
        ld              = ans;
        ld.active_count = act_fin;
        ld.last         = 1'b1;
      end
    end
  end

  // configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size    <= 16'd100;
      decay_ticks  <= 32'd300;
      active_slots <= 5'd16;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rcsp_pkg::CFG_CELL_SIZE:    cell_size    <= cfg_data[15:0];
          rcsp_pkg::CFG_DECAY_TICKS:  decay_ticks  <= cfg_data;
          rcsp_pkg::CFG_ACTIVE_SLOTS: active_slots <= cfg_data[4:0];
          default: ;
        endcase
      end
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= ld;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      apk       <= AP_NONE;
      now       <= '0;
      idx       <= '0;
      emit_recl <= 1'b0;
      emit_asgn <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            op    <= in_data.operation;
            wx    <= in_data.world_x;
            wy    <= in_data.world_y;
            qi    <= in_data.slot_index;
            n     <= n_in;
            cs    <= cs_in;
            if (in_data.operation == rcsp_pkg::OP_TICK) now <= now + 32'd1;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!div_busy) begin
            cx    <= quo_x;
            cy    <= quo_y;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_x <= cx * $signed({1'b0, cs});
          prod_y <= cy * $signed({1'b0, cs});
          idx    <= '0;
          found  <= 1'b0;
          freef  <= 1'b0;
          best   <= 1'b0;
          act    <= '0;
          act_t  <= '0;
          state  <= ST_SCAN;
        end
        ST_SCAN: begin
          if (idx_on) begin
            if (h.valid && h.cell_x == cx && h.cell_y == cy && !found) begin
              found <= 1'b1;
              fidx  <= idx;
              fslot <= h;
            end
            if (!h.valid && !freef) begin
              freef <= 1'b1;
              fridx <= idx;
            end
            if (evictable && (!best || age > bage)) begin
              best <= 1'b1;
              bidx <= idx;
              bage <= age;
              bcx  <= h.cell_x;
              bcy  <= h.cell_y;
            end
            act   <= act + 5'(h.valid);
            act_t <= act_t + 5'(h.valid && !expired);
          end
          if (5'(idx) == {1'b0, qi}) qslot <= h;
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= ST_DECIDE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        ST_DECIDE: begin
          ans      <= '0;
          act_fin  <= act;
          apk      <= AP_NONE;
          state    <= ST_EMIT;
          uz       <= dx[32] || (dx == 33'sd0);
          us       <= dx >= $signed({17'd0, cs});
          vz       <= dy[32] || (dy == 33'sd0);
          vs       <= dy >= $signed({17'd0, cs});
          case (op)
            rcsp_pkg::OP_REGISTER: begin
              ans.cell_x <= cx;
              ans.cell_y <= cy;
              state      <= ST_APPLY;
              if (found) begin
                apk          <= AP_INC;
                tgt          <= fidx;
                ans.slot     <= 4'(fidx);
                ans.origin_x <= fslot.origin_x;
                ans.origin_y <= fslot.origin_y;
                ans.occupied <= 1'b1;
              end else if (freef || best) begin
                apk          <= AP_ASSIGN;
                tgt          <= freef ? fridx : bidx;
                emit_recl    <= !freef;
                emit_asgn    <= 1'b1;
                act_fin      <= freef ? act + 5'd1 : act;
                ans.slot     <= 4'(freef ? fridx : bidx);
                ans.origin_x <= org_x;
                ans.origin_y <= org_y;
                ans.occupied <= 1'b1;
              end else begin
                ans.status <= rcsp_pkg::STAT_EXHAUSTED;
                state      <= ST_EMIT;
              end
            end
            rcsp_pkg::OP_UNREGISTER, rcsp_pkg::OP_LOOKUP: begin
              ans.cell_x <= cx;
              ans.cell_y <= cy;
              if (found) begin
                tgt          <= fidx;
                ans.slot     <= 4'(fidx);
                ans.origin_x <= fslot.origin_x;
                ans.origin_y <= fslot.origin_y;
                ans.occupied <= 1'b1;
                if (op == rcsp_pkg::OP_UNREGISTER) begin
                  apk   <= AP_DEC;
                  state <= ST_APPLY;
                end else begin
                  state <= ST_UV;
                end
              end else begin
                ans.status <= rcsp_pkg::STAT_NOT_FOUND;
              end
            end
            rcsp_pkg::OP_TICK: begin
              apk     <= AP_TICK;
              act_fin <= act_t;
              state   <= ST_APPLY;
            end
            rcsp_pkg::OP_QUERY: begin
              ans.slot <= qi;
              if ({1'b0, qi} >= n) begin
                ans.status <= rcsp_pkg::STAT_BAD_SLOT;
              end else begin
                ans.origin_x <= qslot.origin_x;
                ans.origin_y <= qslot.origin_y;
                if (qslot.valid) begin
                  ans.cell_x   <= qslot.cell_x;
                  ans.cell_y   <= qslot.cell_y;
                  ans.occupied <= 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        ST_APPLY: begin
          if (shift) begin
            if (idx == LAST_IDX) begin
              idx   <= '0;
              state <= ST_EMIT;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end
        ST_UV: begin
          if (!div_busy) begin
            ans.uv_u <= uz ? 16'd0 : us ? rcsp_pkg::UV_MAX : quo_x[15:0];
            ans.uv_v <= vz ? 16'd0 : vs ? rcsp_pkg::UV_MAX : quo_y[15:0];
            state    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (ob_free) begin
            if (emit_recl) begin
              emit_recl <= 1'b0;
            end else if (emit_asgn) begin
              emit_asgn <= 1'b0;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load)
    else $error("beat loaded over a stalled beat");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (load && ld.last) |=> (state == ST_IDLE))
    else $error("answer beat did not end the item");

  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_APPLY) |-> !div_busy)
    else $error("divider busy during a ring pass");

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the refcounted cell slot pool.
// ----------------------------------------------------------------------------
// The bench drives operations over the valid/stall input channel and keeps
// its own model of the slot pool. Each accepted operation queues the beats
// the pool should return. Every returned beat is compared field by field
// with the oldest queued beat. A directed table comes first. After it come
// random phases under several configurations and idle patterns, with one
// long receiver hold-off and one full drain of the sender within a phase.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rcsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_CELL_SIZE;
  logic [31:0] cfg_data = '0;

  refcounted_cell_slot_pool u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pool model
  logic [15:0] cell_sz;
  logic [31:0] decay;
  logic [4:0]  act_slots;
  bit          pv_valid [16];
  int          pv_cx [16];
  int          pv_cy [16];
  int          pv_ox [16];
  int          pv_oy [16];
  int unsigned pv_refs [16];
  bit          pv_rel [16];
  bit [31:0]   pv_rtime [16];
  bit [31:0]   now_ticks;

  out_t pool_beats[$];
  out_t beat_q[$];
  out_t new_beats[$];

  int errors = 0;
  int items_sent = 0;
  int beats_seen = 0;
  int reclaims_seen = 0;
  int assigns_seen = 0;
  int exhausted_seen = 0;
  int idle_mode = 0;
  int hold_seq = 0;

  function automatic int pool_count();
    int n;
    n = act_slots;
    if (n < 1) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  function automatic longint eff_size();
    return (cell_sz < MIN_CELL) ? longint'(MIN_CELL) : longint'(cell_sz);
  endfunction

  function automatic int floor_cell(longint w, longint cs);
    longint q;
    q = w / cs;
    if ((w % cs) != 0 && w < 0) q--;
    return int'(q);
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return INT32_MAX;
    if (v < -64'sd2147483648) return INT32_MIN;
    return int'(v);
  endfunction

  function automatic logic [15:0] uv_frac(longint w, longint org, longint cs);
    longint d;
    longint q;
    d = w - org;
    if (d <= 0) return 16'd0;
    q = (d * 65536) / cs;
    return (q > 65535) ? UV_MAX : 16'(q);
  endfunction

  function automatic void add_beat(logic [1:0] kd, logic [1:0] st, int sl, int cx, int cy,
                                   int ox, int oy, logic [15:0] u, logic [15:0] v, bit occ);
    out_t b;
    b = '0;
    b.kind = kd; b.status = st; b.slot = 4'(sl);
    b.cell_x = cx; b.cell_y = cy; b.origin_x = ox; b.origin_y = oy;
    b.uv_u = u; b.uv_v = v; b.occupied = occ;
    pool_beats.push_back(b);
  endfunction

  function automatic int find_cell(int cx, int cy, int n);
    for (int i = 0; i < n; i++)
      if (pv_valid[i] && pv_cx[i] == cx && pv_cy[i] == cy) return i;
    return -1;
  endfunction

  function automatic void reclaim(int i);
    pv_valid[i] = 0;
    pv_rel[i] = 0;
    pv_ox[i] = FREE_ORIGIN;
    pv_oy[i] = FREE_ORIGIN;
    add_beat(KIND_RECLAIMED, STAT_OK, i, pv_cx[i], pv_cy[i], FREE_ORIGIN, FREE_ORIGIN,
             0, 0, 0);
  endfunction

  function automatic int take_free(int cx, int cy, longint cs, int n);
    for (int i = 0; i < n; i++) begin
      if (!pv_valid[i]) begin
        pv_valid[i] = 1;
        pv_cx[i] = cx; pv_cy[i] = cy;
        pv_ox[i] = clip32(longint'(cx) * cs);
        pv_oy[i] = clip32(longint'(cy) * cs);
        pv_refs[i] = 0;
        pv_rel[i] = 0;
        add_beat(KIND_ASSIGNED, STAT_OK, i, cx, cy, pv_ox[i], pv_oy[i], 0, 0, 1);
        return i;
      end
    end
    return -1;
  endfunction

  // Work out the beats of one operation and update the pool model.
  function automatic void pool_step(in_t it);
    int n, s, best, cx, cy, act;
    longint cs, wx, wy;
    bit [31:0] best_age, age;
    n = pool_count();
    cs = eff_size();
    wx = longint'(it.world_x);
    wy = longint'(it.world_y);
    cx = floor_cell(wx, cs);
    cy = floor_cell(wy, cs);
    act = 0;
    pool_beats.delete();
    case (it.operation)
      OP_REGISTER: begin
        s = find_cell(cx, cy, n);
        if (s < 0) s = take_free(cx, cy, cs, n);
        if (s < 0) begin
          best = -1;
          best_age = 0;
          for (int i = 0; i < n; i++) begin
            if (!pv_valid[i] || pv_refs[i] > 0 || !pv_rel[i]) continue;
            age = now_ticks - pv_rtime[i];
            if (best < 0 || age > best_age) begin
              best = i;
              best_age = age;
            end
          end
          if (best >= 0) begin
            reclaim(best);
            s = take_free(cx, cy, cs, n);
          end
        end
        if (s < 0) begin
          add_beat(KIND_ANSWER, STAT_EXHAUSTED, 0, cx, cy, 0, 0, 0, 0, 0);
        end else begin
          if (pv_refs[s] < 32'hFFFF) pv_refs[s]++;
          pv_rel[s] = 0;
          add_beat(KIND_ANSWER, STAT_OK, s, cx, cy, pv_ox[s], pv_oy[s], 0, 0, 1);
        end
      end
      OP_UNREGISTER: begin
        s = find_cell(cx, cy, n);
        if (s < 0) begin
          add_beat(KIND_ANSWER, STAT_NOT_FOUND, 0, cx, cy, 0, 0, 0, 0, 0);
        end else begin
          if (pv_refs[s] > 0) pv_refs[s]--;
          if (pv_refs[s] == 0) begin
            pv_rel[s] = 1;
            pv_rtime[s] = now_ticks;
          end
          add_beat(KIND_ANSWER, STAT_OK, s, cx, cy, pv_ox[s], pv_oy[s], 0, 0, 1);
        end
      end
      OP_LOOKUP: begin
        s = find_cell(cx, cy, n);
        if (s < 0) begin
          add_beat(KIND_ANSWER, STAT_NOT_FOUND, 0, cx, cy, 0, 0, 0, 0, 0);
        end else begin
          add_beat(KIND_ANSWER, STAT_OK, s, cx, cy, pv_ox[s], pv_oy[s],
                   uv_frac(wx, pv_ox[s], cs), uv_frac(wy, pv_oy[s], cs), 1);
        end
      end
      OP_TICK: begin
        now_ticks++;
        for (int i = 0; i < n; i++) begin
          if (!pv_valid[i] || pv_refs[i] > 0 || !pv_rel[i]) continue;
          if ((now_ticks - pv_rtime[i]) < decay) continue;
          reclaim(i);
        end
        add_beat(KIND_ANSWER, STAT_OK, 0, 0, 0, 0, 0, 0, 0, 0);
      end
      OP_QUERY: begin
        s = it.slot_index;
        if (s >= n)
          add_beat(KIND_ANSWER, STAT_BAD_SLOT, s, 0, 0, 0, 0, 0, 0, 0);
        else if (pv_valid[s])
          add_beat(KIND_ANSWER, STAT_OK, s, pv_cx[s], pv_cy[s], pv_ox[s], pv_oy[s], 0, 0, 1);
        else
          add_beat(KIND_ANSWER, STAT_OK, s, 0, 0, pv_ox[s], pv_oy[s], 0, 0, 0);
      end
      default: add_beat(KIND_ANSWER, STAT_OK, 0, 0, 0, 0, 0, 0, 0, 0);
    endcase
    for (int i = 0; i < n; i++)
      if (pv_valid[i]) act++;
    foreach (pool_beats[k]) begin
      pool_beats[k].active_count = 5'(act);
      pool_beats[k].last = (k == pool_beats.size() - 1);
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch @%0t beat %0d: %s got %0h want %0h", $realtime, beats_seen, what,
             got, want);
  endtask

  // Compare each returned beat with the oldest expected one.
  always @(posedge clk) begin
    out_t w;
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (beat_q.size() == 0) begin
        report("unexpected beat", out_data.kind, 0);
      end else begin
        w = beat_q.pop_front();
        if (out_data.kind != w.kind) report("kind", out_data.kind, w.kind);
        if (out_data.status != w.status) report("status", out_data.status, w.status);
        if (out_data.slot != w.slot) report("slot", out_data.slot, w.slot);
        if (out_data.cell_x != w.cell_x) report("cell_x", out_data.cell_x, w.cell_x);
        if (out_data.cell_y != w.cell_y) report("cell_y", out_data.cell_y, w.cell_y);
        if (out_data.origin_x != w.origin_x) report("origin_x", out_data.origin_x, w.origin_x);
        if (out_data.origin_y != w.origin_y) report("origin_y", out_data.origin_y, w.origin_y);
        if (out_data.uv_u != w.uv_u) report("uv_u", out_data.uv_u, w.uv_u);
        if (out_data.uv_v != w.uv_v) report("uv_v", out_data.uv_v, w.uv_v);
        if (out_data.occupied != w.occupied) report("occupied", out_data.occupied, w.occupied);
        if (out_data.active_count != w.active_count)
          report("active_count", out_data.active_count, w.active_count);
        if (out_data.last != w.last) report("last", out_data.last, w.last);
        if (w.kind == KIND_RECLAIMED) reclaims_seen++;
        if (w.kind == KIND_ASSIGNED) assigns_seen++;
        if (w.status == STAT_EXHAUSTED) exhausted_seen++;
      end
    end
  end

  // Receiver: random stall per idle mode, plus a long hold-off on request.
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (idle_mode)
        2: out_stall <= ($urandom_range(99) < 64);
        3: out_stall <= ($urandom_range(99) < 8);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Watchdog on cycles with no beat moving on either channel.
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("** refcounted_cell_slot_pool: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(in_t it);
    int gap;
    gap = 0;
    if ((idle_mode == 1 && $urandom_range(99) < 64) ||
        (idle_mode == 3 && $urandom_range(99) < 8))
      gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      in_valid <= 1'b1;
    end else if (!in_valid) begin
      in_valid <= 1'b1;
    end
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pool_step(it);
    new_beats = pool_beats;
    foreach (new_beats[k]) beat_q.push_back(new_beats[k]);
    items_sent++;
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (beat_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CELL_SIZE:   cell_sz = val[15:0];
      CFG_DECAY_TICKS: decay = val;
      default:         act_slots = val[4:0];
    endcase
  endtask

  function automatic int near_world();
    longint cs;
    cs = eff_size();
    if ($urandom_range(99) < 80)
      return clip32((longint'($urandom_range(6)) - 3) * cs + longint'($urandom_range(cs - 1)));
    return int'($urandom);
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int r;
    r = $urandom_range(99);
    it.operation = (r < 36) ? OP_REGISTER : (r < 56) ? OP_UNREGISTER : (r < 74) ? OP_LOOKUP :
                   (r < 88) ? OP_TICK : (r < 97) ? OP_QUERY : 3'($urandom_range(5, 7));
    it.world_x = near_world();
    it.world_y = near_world();
    it.slot_index = 4'($urandom_range(15));
    return it;
  endfunction

  typedef struct {
    in_t  item;
    bit   typed;
    out_t answer;
  } row_t;

  function automatic row_t mk(logic [2:0] op, int wx, int wy, int idx);
    row_t r;
    r.item.operation = op;
    r.item.world_x = wx;
    r.item.world_y = wy;
    r.item.slot_index = 4'(idx);
    r.typed = 0;
    r.answer = '0;
    return r;
  endfunction

  function automatic row_t typed_row(row_t r, logic [1:0] st, int sl, int cx, int cy, int org);
    r.typed = 1;
    r.answer = '0;
    r.answer.kind = KIND_ANSWER;
    r.answer.status = st;
    r.answer.slot = 4'(sl);
    r.answer.cell_x = cx;
    r.answer.cell_y = cy;
    r.answer.origin_x = org;
    r.answer.origin_y = org;
    r.answer.last = 1'b1;
    return r;
  endfunction

  row_t table_rows[$];

  initial begin
    row_t r;
    cell_sz = 16'd100;
    decay = 32'd300;
    act_slots = 5'd16;
    now_ticks = 0;
    for (int i = 0; i < 16; i++) begin
      pv_valid[i] = 0; pv_cx[i] = 0; pv_cy[i] = 0;
      pv_ox[i] = FREE_ORIGIN; pv_oy[i] = FREE_ORIGIN;
      pv_refs[i] = 0; pv_rel[i] = 0; pv_rtime[i] = 0;
    end

    // after reset, error answers, extremes
    table_rows.push_back(typed_row(mk(OP_QUERY, 0, 0, 0), STAT_OK, 0, 0, 0, FREE_ORIGIN));
    table_rows.push_back(typed_row(mk(OP_QUERY, 0, 0, 15), STAT_OK, 15, 0, 0, FREE_ORIGIN));
    table_rows.push_back(typed_row(mk(OP_TICK, 5, 5, 0), STAT_OK, 0, 0, 0, 0));
    table_rows.push_back(typed_row(mk(3'd5, -1, -1, 7), STAT_OK, 0, 0, 0, 0));
    table_rows.push_back(typed_row(mk(3'd7, 0, 0, 15), STAT_OK, 0, 0, 0, 0));
    table_rows.push_back(typed_row(mk(OP_LOOKUP, 0, 0, 0), STAT_NOT_FOUND, 0, 0, 0, 0));
    table_rows.push_back(typed_row(mk(OP_UNREGISTER, 150, -150, 0), STAT_NOT_FOUND, 0, 1, -2,
                                   0));
    table_rows.push_back(mk(OP_REGISTER, INT32_MAX, INT32_MIN, 0));
    table_rows.push_back(mk(OP_REGISTER, -1, 99, 0));
    table_rows.push_back(mk(OP_LOOKUP, -1, 99, 0));
    table_rows.push_back(mk(OP_REGISTER, -50, 0, 0));
    table_rows.push_back(mk(OP_LOOKUP, INT32_MAX, INT32_MIN, 0));
    table_rows.push_back(mk(OP_UNREGISTER, -1, 99, 0));
    table_rows.push_back(mk(OP_UNREGISTER, -1, 99, 0));
    table_rows.push_back(mk(OP_UNREGISTER, -1, 99, 0));
    table_rows.push_back(mk(OP_REGISTER, 32'h55555555, 32'hAAAAAAAA, 0));
    table_rows.push_back(mk(OP_LOOKUP, 32'h55555555, 32'hAAAAAAAA, 0));
    table_rows.push_back(mk(OP_QUERY, 0, 0, 1));
    table_rows.push_back(mk(OP_QUERY, 0, 0, 10));
    table_rows.push_back(mk(OP_TICK, 0, 0, 0));
    table_rows.push_back(mk(6, INT32_MIN, INT32_MAX, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[k]) begin
      r = table_rows[k];
      send(r.item);
      // typed rows give a single answer: replace the model's beat with it
      if (r.typed) begin
        r.answer.active_count = beat_q[$].active_count;
        void'(beat_q.pop_back());
        beat_q.push_back(r.answer);
      end
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_CELL_SIZE, 32'd100);
          write_reg(CFG_DECAY_TICKS, 32'd2);
          write_reg(CFG_ACTIVE_SLOTS, 32'd4);
        end
        1: begin
          // cells stay assigned across the size change
          write_reg(CFG_CELL_SIZE, 32'd65535);
          write_reg(CFG_DECAY_TICKS, 32'd0);
          write_reg(CFG_ACTIVE_SLOTS, 32'd16);
        end
        2: begin
          write_reg(CFG_CELL_SIZE, 32'd37);
          write_reg(CFG_DECAY_TICKS, 32'hFFFFFFFF);
          write_reg(CFG_ACTIVE_SLOTS, 32'd0);
        end
        default: begin
          write_reg(CFG_CELL_SIZE, 32'd250);
          write_reg(CFG_DECAY_TICKS, 32'd3);
          write_reg(CFG_ACTIVE_SLOTS, 32'd31);
        end
      endcase
      idle_mode <= ph;
      @(posedge clk);
      if (ph == 0) hold_seq <= hold_seq + 1;
      for (int k = 0; k < 40; k++) begin
        if (ph == 2 && k == 20) drain();
        send(rand_item());
      end
      drain();
    end

    repeat (100) @(posedge clk);
    $display("covered %0d operations, %0d beats: %0d assigned, %0d reclaimed, %0d exhausted",
             items_sent, beats_seen, assigns_seen, reclaims_seen, exhausted_seen);
    $display("config sweeps over cell size, decay and active slots; %0d mismatches", errors);
    if (errors == 0 && beat_q.size() == 0) begin
      $display("** refcounted_cell_slot_pool: PASSED **");
    end else begin
      $display("** refcounted_cell_slot_pool: FAILED **");
    end
    $finish;
  end

endmodule
